### hw/rtl/u16u8_pkg.sv
// Shared types, constants and helper functions for the UTF-16LE to UTF-8 converter.
// No dependencies; every other file in hw/rtl except the checker imports this package.
`timescale 1ns / 1ps

package u16u8_pkg;

  // Width of the per-string byte counter, which saturates at all ones.
  localparam int COUNT_WIDTH = 10;

  localparam int UNIT_W       = 16;
  localparam int BYTE_W       = 8;
  localparam int BYTE_COUNT_W = 10;
  localparam int MAX_BYTES    = 3;
  localparam int NBYTES_W     = 2;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

  localparam logic [BYTE_COUNT_W-1:0] BYTE_COUNT_MAX = '1;

  // Lead and continuation markers of UTF-8, surrogate prefixes and the low-byte bias.
  localparam logic [7:0] LEAD4_BASE = 8'hf0;
  localparam logic [4:0] HI_SURR_ANY = 5'b11011;   // top bits of 0xd8..0xdf
  localparam logic [5:0] LO_SURR_TOP = 6'b110111;  // top bits of 0xdc..0xdf
  localparam logic [1:0] CONT_MARK   = 2'b10;
  localparam logic [1:0] LEAD2_MARK  = 2'b11;
  localparam logic [3:0] LEAD3_MARK  = 4'he;
  localparam logic [7:0] LO_BIAS     = 8'h40;

  typedef enum logic [2:0] {
    MODE_BASE = 3'b001,
    MODE_SURR = 3'b010,
    MODE_ERR  = 3'b100
  } u16u8_mode_e;

  // One classified code unit, as passed from the front to the back.
  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;   // bytes[0] goes out first
    logic [NBYTES_W-1:0]              nbytes;  // 0 to 3
    logic                             last;    // status result follows
    logic                             err;     // string ended in error
  } u16u8_entry_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } u16u8_q_ctrl_t;

  // Caps the running count to the width of the reported byte count.
  function automatic logic [BYTE_COUNT_W-1:0] cap_count(
    input logic [COUNT_WIDTH-1:0] cnt
  );
    localparam int ExtW = (COUNT_WIDTH > BYTE_COUNT_W) ? COUNT_WIDTH : BYTE_COUNT_W;
    logic [ExtW-1:0] ext;
    logic [BYTE_COUNT_W-1:0] res;
    ext = ExtW'(cnt);
    if (ext > ExtW'(BYTE_COUNT_MAX)) begin
      res = BYTE_COUNT_MAX;
    end else begin
      res = ext[BYTE_COUNT_W-1:0];
    end
    return res;
  endfunction

endpackage

### hw/rtl/utf16le_to_utf8_converter.sv
// A code unit passes through the queue and then the output register before its first result is presented.
// One result per cycle while the output is not stalled, each unit giving zero to three byte results (plus
// the status result on the last unit of a string); the single-result output register sets this rate.
// Reset (rst_ni low, asynchronous): queue empty, output invalid, decoder in base mode,
// held bits and byte count cleared.
`timescale 1ns / 1ps

module utf16le_to_utf8_converter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [u16u8_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,   // [15:0] code_unit
  input  logic                                s_axis_tlast_i,   // is_last
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [7:0] out_byte, [8] error, [18:9] byte_count, zero above
  output logic [u16u8_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic [u16u8_pkg::OUT_TUSER_W-1:0]   m_axis_tuser_o,   // [0] byte_valid, [1] done_res
  output logic                                m_axis_tlast_o    // run_end
);
  import u16u8_pkg::*;

  u16u8_entry_t  push_data, pop_data;
  logic          push, full;
  logic          q_valid;
  u16u8_q_ctrl_t q_ctrl;

  logic [BYTE_W-1:0]       out_byte;
  logic                    byte_valid, done_res, err;
  logic [BYTE_COUNT_W-1:0] byte_count;

  u16u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .code_unit_i (s_axis_tdata_i[UNIT_W-1:0]),
    .is_last_i   (s_axis_tlast_i),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_data_o    (push_data)
  );

  u16u8_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (q_ctrl.pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  u16u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (pop_data),
    .q_valid_i    (q_valid),
    .q_ctrl_o     (q_ctrl),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (out_byte),
    .byte_valid_o (byte_valid),
    .run_end_o    (m_axis_tlast_o),
    .done_res_o   (done_res),
    .error_o      (err),
    .byte_count_o (byte_count)
  );

  assign m_axis_tdata_o = {5'd0, byte_count, err, out_byte};
  assign m_axis_tuser_o = {done_res, byte_valid};

endmodule

### hw/rtl/u16u8_fifo.sv
// Short queue of classified code units between the decoder front and the emitter back.
// Depends on u16u8_pkg for the entry type and queue depth.
`timescale 1ns / 1ps

module u16u8_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  u16u8_pkg::u16u8_entry_t push_data_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    valid_o,
  output u16u8_pkg::u16u8_entry_t pop_data_o
);
  import u16u8_pkg::*;

  u16u8_entry_t mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/u16u8_front.sv
// Decoder front: accepts code units, tracks surrogate state and builds the byte list.
// Depends on u16u8_pkg for the mode enum and the queue entry type.
`timescale 1ns / 1ps

module u16u8_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [u16u8_pkg::UNIT_W-1:0] code_unit_i,
  input  logic                       is_last_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output u16u8_pkg::u16u8_entry_t    q_data_o
);
  import u16u8_pkg::*;

  u16u8_mode_e mode_q, mode_d;
  logic [1:0]  held_q, held_d;

  logic [7:0] hi, lo;
  logic [7:0] lo_biased;
  u16u8_mode_e mode_next;
  logic        accept;

  assign hi         = code_unit_i[15:8];
  assign lo         = code_unit_i[7:0];
  assign lo_biased  = lo + LO_BIAS;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o        = '0;
    mode_next       = mode_q;
    held_d          = held_q;
    case (mode_q)
      MODE_BASE: begin
        if (hi[7:3] != '0) begin
          if (hi[7:3] == HI_SURR_ANY) begin
            if (hi[2]) begin
              mode_next = MODE_ERR;
            end else begin
              q_data_o.bytes[0] = LEAD4_BASE + {6'd0, hi[1:0]}
                                  + {7'd0, (lo[7:6] == 2'b11)};
              q_data_o.bytes[1] = {CONT_MARK, lo_biased[7:2]};
              q_data_o.nbytes   = NBYTES_W'(2);
              held_d            = lo[1:0];
              mode_next         = MODE_SURR;
            end
          end else begin
            q_data_o.bytes[0] = {LEAD3_MARK, hi[7:4]};
            q_data_o.bytes[1] = {CONT_MARK, hi[3:0], lo[7:6]};
            q_data_o.bytes[2] = {CONT_MARK, lo[5:0]};
            q_data_o.nbytes   = NBYTES_W'(3);
          end
        end else if (lo[7] || (hi != '0)) begin
          q_data_o.bytes[0] = {LEAD2_MARK, hi[3:0], lo[7:6]};
          q_data_o.bytes[1] = {CONT_MARK, lo[5:0]};
          q_data_o.nbytes   = NBYTES_W'(2);
        end else begin
          q_data_o.bytes[0] = lo;
          q_data_o.nbytes   = NBYTES_W'(1);
        end
      end
      MODE_SURR: begin
        if (hi[7:2] == LO_SURR_TOP) begin
          q_data_o.bytes[0] = {CONT_MARK, held_q, hi[1:0], lo[7:6]};
          q_data_o.bytes[1] = {CONT_MARK, lo[5:0]};
          q_data_o.nbytes   = NBYTES_W'(2);
          mode_next         = MODE_BASE;
        end else begin
          mode_next = MODE_ERR;
        end
      end
      default: begin
        mode_next = MODE_ERR;
      end
    endcase
    q_data_o.last = is_last_i;
    q_data_o.err  = (mode_next != MODE_BASE);
  end

  // Units in error mode, or that move into it, leave nothing to emit and are not pushed unless they end the string.
  assign q_push_o = accept && ((q_data_o.nbytes != '0) || is_last_i);

  always_comb begin
    mode_d = mode_q;
    if (accept) begin
      mode_d = is_last_i ? MODE_BASE : mode_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BASE;
      held_q <= '0;
    end else begin
      mode_q <= mode_d;
      if (accept) begin
        held_q <= is_last_i ? 2'b00 : held_d;
      end
    end
  end

endmodule

### hw/rtl/u16u8_back.sv
// Emitter back: walks each queued entry into the output register, one result per cycle unless the output stalls.
// Depends on u16u8_pkg for the entry type, counter width and count capping.
`timescale 1ns / 1ps

module u16u8_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  u16u8_pkg::u16u8_entry_t           entry_i,
  input  logic                              q_valid_i,
  output u16u8_pkg::u16u8_q_ctrl_t          q_ctrl_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [u16u8_pkg::BYTE_W-1:0]      out_byte_o,
  output logic                              byte_valid_o,
  output logic                              run_end_o,
  output logic                              done_res_o,
  output logic                              error_o,
  output logic [u16u8_pkg::BYTE_COUNT_W-1:0] byte_count_o
);
  import u16u8_pkg::*;

  logic [NBYTES_W-1:0]    idx_q, idx_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;

  logic [BYTE_W-1:0]       byte_q;
  logic                    byte_valid_q, run_end_q, done_q, err_q;
  logic [BYTE_COUNT_W-1:0] count_out_q;

  logic              advance, is_byte, run_end;
  logic [BYTE_W-1:0] sel_byte;

  assign advance = q_valid_i && (!out_valid_q || out_ready_i);
  assign is_byte = (idx_q < entry_i.nbytes);
  assign run_end = entry_i.last ? !is_byte : ((idx_q + 1'b1) == entry_i.nbytes);

  assign q_ctrl_o.valid = q_valid_i;
  assign q_ctrl_o.pop   = advance && run_end;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = entry_i.bytes[0];
      2'd1:    sel_byte = entry_i.bytes[1];
      2'd2:    sel_byte = entry_i.bytes[2];
      default: sel_byte = '0;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      idx_d       = run_end ? '0 : idx_q + 1'b1;
      if (is_byte) begin
        if (cnt_q != '1) begin
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        // The status result closes the string, so the count starts afresh.
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q       <= is_byte ? sel_byte : '0;
      byte_valid_q <= is_byte;
      run_end_q    <= run_end;
      done_q       <= !is_byte;
      err_q        <= !is_byte && entry_i.err;
      count_out_q  <= (is_byte || entry_i.err) ? '0 : cap_count(cnt_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = byte_valid_q;
  assign run_end_o    = run_end_q;
  assign done_res_o   = done_q;
  assign error_o      = err_q;
  assign byte_count_o = count_out_q;

endmodule

### hw/rtl/u16u8_checker.sv
// Port-level checker for the UTF-16LE to UTF-8 converter, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module u16u8_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // Every result is either a byte or the closing status, never both or neither.
  a_kind_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[0] != m_axis_tuser_o[1]))
    else $error("result is neither a byte nor a status");

  // The status result is always the final result of its request.
  a_status_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> m_axis_tlast_o)
    else $error("status result without tlast");

  // Byte results carry no error flag and no count.
  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o[23:8] == 16'd0))
    else $error("byte result with status fields set");

  // A string that ended in error reports a zero length.
  a_error_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1] && m_axis_tdata_o[8])
      |-> (m_axis_tdata_o[18:9] == 10'd0))
    else $error("error status with non-zero count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
       && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind utf16le_to_utf8_converter u16u8_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
